### hw/rtl/lralu_pkg.sv
// ----------------------------------------------------------------------------
// lralu_pkg: shared types for the 8-bit accumulator/flags ALU
// Command codes, flag word layout and the input and result word records.
// ----------------------------------------------------------------------------
package lralu_pkg;

  // Operation select, in command code order
  typedef enum logic [4:0] {
    CMD_ADD     = 5'd0,
    CMD_ADC     = 5'd1,
    CMD_SUB     = 5'd2,
    CMD_SBC     = 5'd3,
    CMD_AND     = 5'd4,
    CMD_OR      = 5'd5,
    CMD_XOR     = 5'd6,
    CMD_CP      = 5'd7,
    CMD_INC8    = 5'd8,
    CMD_DEC8    = 5'd9,
    CMD_INC16   = 5'd10,
    CMD_DEC16   = 5'd11,
    CMD_DAA     = 5'd12,
    CMD_RLC     = 5'd13,
    CMD_RLCA    = 5'd14,
    CMD_RL      = 5'd15,
    CMD_RLA     = 5'd16,
    CMD_RRC     = 5'd17,
    CMD_RRCA    = 5'd18,
    CMD_RR      = 5'd19,
    CMD_RRA     = 5'd20,
    CMD_SLA     = 5'd21,
    CMD_SRA     = 5'd22,
    CMD_SRL     = 5'd23,
    CMD_SWAP    = 5'd24,
    CMD_BIT     = 5'd25,
    CMD_RES     = 5'd26,
    CMD_SET     = 5'd27,
    CMD_ADD_HL  = 5'd28,
    CMD_ADD_SP  = 5'd29,
    CMD_LD_HLSP = 5'd30,
    CMD_LOAD_AF = 5'd31
  } cmd_t;

  // Flag word, Z in the top bit
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // One input word
  typedef struct packed {
    cmd_t              command;
    logic [7:0]        operand8;
    logic [15:0]       operand16;
    logic signed [7:0] offset;
    logic [2:0]        bit_index;
    logic [15:0]       hl_in;
    logic [15:0]       sp_in;
  } in_word_t;

  // One result word
  typedef struct packed {
    logic [7:0]  result8;
    logic [15:0] result16;
    logic [15:0] sp_out;
    logic [7:0]  acc;
    flags_t      flags;
  } out_word_t;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = 5;
  localparam int unsigned OUT_TDATA_W = 56;

endpackage

### hw/rtl/lralu_core.sv
// ----------------------------------------------------------------------------
// lralu_core: single-pass ALU datapath
// Executes one command against the current accumulator and flags and yields
// the result word together with the next accumulator and flags.
// ----------------------------------------------------------------------------
module lralu_core (
  input  lralu_pkg::in_word_t  item,
  input  logic [7:0]           acc_cur,
  input  lralu_pkg::flags_t    flags_cur,
  output lralu_pkg::out_word_t result,
  output logic [7:0]           acc_next,
  output lralu_pkg::flags_t    flags_next
);

  logic [7:0]        a;
  logic [7:0]        v;
  logic [15:0]       w;
  logic [7:0]        off;
  logic [15:0]       offx;
  logic              cin;
  logic [8:0]        sum9;
  logic [4:0]        nib5;
  logic [8:0]        dif9;
  logic [8:0]        vcin9;
  logic [8:0]        daa9;
  logic [7:0]        rot;
  logic [7:0]        bmask;
  logic [16:0]       hlsum;
  logic [12:0]       hl12;
  logic [8:0]        splo;
  logic [15:0]       spsum;
  logic [7:0]        r8;
  logic [15:0]       r16;
  logic [15:0]       spo;
  logic [7:0]        a_n;
  lralu_pkg::flags_t f;

  assign a     = acc_cur;
  assign v     = item.operand8;
  assign w     = item.operand16;
  assign off   = item.offset;
  assign offx  = {{8{off[7]}}, off};
  assign bmask = 8'd1 << item.bit_index;

  // Shared adders
  always_comb begin
    cin   = ((item.command == lralu_pkg::CMD_ADC) || (item.command == lralu_pkg::CMD_SBC))
            & flags_cur.c;
    sum9  = {1'b0, a} + {1'b0, v} + {8'd0, cin};
    nib5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
    dif9  = {1'b0, a} - {1'b0, v} - {8'd0, cin};
    vcin9 = {1'b0, v} + {8'd0, cin};
    hlsum = {1'b0, item.hl_in} + {1'b0, w};
    hl12  = {1'b0, item.hl_in[11:0]} + {1'b0, w[11:0]};
    splo  = {1'b0, item.sp_in[7:0]} + {1'b0, off};
    spsum = item.sp_in + offx;
  end

  // Decimal adjust of the accumulator
  always_comb begin
    daa9 = {1'b0, a};
    if (flags_cur.n) begin
      if (flags_cur.h) begin
        daa9 = {1'b0, daa9[7:0] - 8'h06};
      end
      if (flags_cur.c) begin
        daa9 = daa9 - 9'h060;
      end
    end else begin
      if (flags_cur.h || (a[3:0] > 4'd9)) begin
        daa9 = daa9 + 9'h006;
      end
      if (flags_cur.c || (daa9 > 9'h09F)) begin
        daa9 = daa9 + 9'h060;
      end
    end
  end

  // Command decode
  always_comb begin
    r8  = 8'd0;
    r16 = 16'd0;
    spo = item.sp_in;
    a_n = a;
    f   = flags_cur;
    rot = 8'd0;
    case (item.command)
      lralu_pkg::CMD_ADD, lralu_pkg::CMD_ADC: begin
        a_n = sum9[7:0];
        f.h = nib5[4];
        f.c = sum9[8];
        f.z = (sum9[7:0] == 8'd0);
        f.n = 1'b0;
      end
      lralu_pkg::CMD_SUB, lralu_pkg::CMD_SBC, lralu_pkg::CMD_CP: begin
        if (item.command != lralu_pkg::CMD_CP) begin
          a_n = dif9[7:0];
        end
        f.h = a[4] ^ v[4] ^ dif9[4];
        f.c = ({1'b0, a} < vcin9);
        f.n = 1'b1;
        f.z = (dif9[7:0] == 8'd0);
      end
      lralu_pkg::CMD_AND: begin
        a_n = a & v;
        f   = '{z: ((a & v) == 8'd0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      lralu_pkg::CMD_OR: begin
        a_n = a | v;
        f   = '{z: ((a | v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      lralu_pkg::CMD_XOR: begin
        a_n = a ^ v;
        f   = '{z: ((a ^ v) == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      lralu_pkg::CMD_INC8: begin
        r8  = v + 8'd1;
        f.h = (v[3:0] == 4'hF);
        f.z = (v == 8'hFF);
        f.n = 1'b0;
      end
      lralu_pkg::CMD_DEC8: begin
        r8  = v - 8'd1;
        f.h = (v[3:0] == 4'h0);
        f.z = (v == 8'h01);
        f.n = 1'b1;
      end
      lralu_pkg::CMD_INC16: begin
        r16 = w + 16'd1;
      end
      lralu_pkg::CMD_DEC16: begin
        r16 = w - 16'd1;
      end
      lralu_pkg::CMD_DAA: begin
        a_n = daa9[7:0];
        f.c = flags_cur.c | daa9[8];
        f.z = (daa9[7:0] == 8'd0);
        f.h = 1'b0;
      end
      lralu_pkg::CMD_RLC: begin
        rot = {v[6:0], v[7]};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      lralu_pkg::CMD_RLCA: begin
        a_n = {a[6:0], a[7]};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      lralu_pkg::CMD_RL: begin
        rot = {v[6:0], flags_cur.c};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      lralu_pkg::CMD_RLA: begin
        a_n = {a[6:0], flags_cur.c};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[7]};
      end
      lralu_pkg::CMD_RRC: begin
        rot = {v[0], v[7:1]};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      lralu_pkg::CMD_RRCA: begin
        a_n = {a[0], a[7:1]};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      lralu_pkg::CMD_RR: begin
        rot = {flags_cur.c, v[7:1]};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      lralu_pkg::CMD_RRA: begin
        a_n = {flags_cur.c, a[7:1]};
        f   = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a[0]};
      end
      lralu_pkg::CMD_SLA: begin
        rot = {v[6:0], 1'b0};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: v[7]};
      end
      lralu_pkg::CMD_SRA: begin
        rot = {v[7], v[7:1]};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      lralu_pkg::CMD_SRL: begin
        rot = {1'b0, v[7:1]};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: v[0]};
      end
      lralu_pkg::CMD_SWAP: begin
        rot = {v[3:0], v[7:4]};
        r8  = rot;
        f   = '{z: (rot == 8'd0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      lralu_pkg::CMD_BIT: begin
        f.z = ((v & bmask) == 8'd0);
        f.n = 1'b0;
        f.h = 1'b1;
      end
      lralu_pkg::CMD_RES: begin
        r8 = v & ~bmask;
      end
      lralu_pkg::CMD_SET: begin
        r8 = v | bmask;
      end
      lralu_pkg::CMD_ADD_HL: begin
        r16 = hlsum[15:0];
        f.h = hl12[12];
        f.c = hlsum[16];
        f.n = 1'b0;
      end
      lralu_pkg::CMD_ADD_SP, lralu_pkg::CMD_LD_HLSP: begin
        if (item.command == lralu_pkg::CMD_ADD_SP) begin
          spo = spsum;
        end else begin
          r16 = spsum;
        end
        f.c = splo[8];
        f.h = (({1'b0, item.sp_in[3:0]} + {1'b0, off[3:0]}) > 5'h0F);
        f.z = 1'b0;
        f.n = 1'b0;
      end
      lralu_pkg::CMD_LOAD_AF: begin
        a_n = w[15:8];
        f   = '{z: w[7], n: w[6], h: w[5], c: w[4]};
      end
      default: begin
        a_n = a;
      end
    endcase
  end

  assign acc_next        = a_n;
  assign flags_next      = f;
  assign result.result8  = r8;
  assign result.result16 = r16;
  assign result.sp_out   = spo;
  assign result.acc      = a_n;
  assign result.flags    = f;

endmodule

### hw/rtl/lr35902_alu_flags.sv
// Each word goes through the input register and then the result register.
// Throughput: one word per cycle unless m_axis stalls; the input register,
//   accumulator/flags update and result register advance together in one pass.
// Stalls on m_axis hold the result register and backpressure the input.
// Reset (rst, synchronous) clears A, the flags and both pipeline valids.
// ----------------------------------------------------------------------------
// lr35902_alu_flags: 8-bit accumulator ALU with Z/N/H/C flags
// Input register, single-pass ALU datapath and result register with a
// registered accumulator and flag word updated as each command completes.
// ----------------------------------------------------------------------------
module lr35902_alu_flags (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // command[4:0]
  input  logic [lralu_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
  // operand8[7:0], operand16[23:8], offset[31:24], bit_index[34:32],
  // hl_in[50:35], sp_in[66:51], zero[71:67]
  input  logic [lralu_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // result8[7:0], result16[23:8], sp_out[39:24], acc[47:40], flag_zero[48],
  // flag_subtract[49], flag_half[50], flag_carry[51], zero[55:52]
  output logic [lralu_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  logic                 in_valid;
  lralu_pkg::in_word_t  in_item;
  lralu_pkg::in_word_t  in_unpacked;
  logic                 out_valid;
  lralu_pkg::out_word_t out_item;
  lralu_pkg::out_word_t core_result;
  logic [7:0]           acc;
  logic [7:0]           acc_next;
  lralu_pkg::flags_t    flags;
  lralu_pkg::flags_t    flags_next;
  logic                 advance;
  logic                 take;

  // Unpack the incoming word
  always_comb begin
    in_unpacked.command   = lralu_pkg::cmd_t'(s_axis_tuser);
    in_unpacked.operand8  = s_axis_tdata[7:0];
    in_unpacked.operand16 = s_axis_tdata[23:8];
    in_unpacked.offset    = s_axis_tdata[31:24];
    in_unpacked.bit_index = s_axis_tdata[34:32];
    in_unpacked.hl_in     = s_axis_tdata[50:35];
    in_unpacked.sp_in     = s_axis_tdata[66:51];
  end

  // Pipeline handshake
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  lralu_core u_core (
    .item       (in_item),
    .acc_cur    (acc),
    .flags_cur  (flags),
    .result     (core_result),
    .acc_next   (acc_next),
    .flags_next (flags_next)
  );

  // Hold the input word until the datapath takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_item <= in_unpacked;
    end
  end

  // Advance accumulator and flags as each command completes
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 8'd0;
      flags <= '0;
    end else if (advance) begin
      acc   <= acc_next;
      flags <= flags_next;
    end
  end

  // Result register; drop the valid once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= core_result;
    end
  end

  // Pack the result word
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0,
                          out_item.flags.c,
                          out_item.flags.h,
                          out_item.flags.n,
                          out_item.flags.z,
                          out_item.acc,
                          out_item.sp_out,
                          out_item.result16,
                          out_item.result8};

endmodule

### test/lr35902_alu_flags_checker.sv
// ----------------------------------------------------------------------------
// lr35902_alu_flags_checker: result checker for the accumulator/flags ALU
// Watches both stream channels, tracks its own A and Z/N/H/C state, predicts
// the result word for every accepted input word and compares it, field by
// field, with the words that leave the block in order.
// ----------------------------------------------------------------------------
module lr35902_alu_flags_checker
  import lralu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [IN_TUSER_W-1:0]  in_user,
  input  logic [IN_TDATA_W-1:0]  in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [OUT_TDATA_W-1:0] out_data,
  output int                     mismatches,
  output int                     outstanding
);

  out_word_t  alu_result_q[$];
  logic [7:0] acc_model;
  flags_t     flag_model;
  int         fail_cnt;

  initial begin
    fail_cnt    = 0;
    acc_model   = '0;
    flag_model  = '0;
  end

  // Compute one ALU command from the current A and flags
  function automatic out_word_t alu_predict(input cmd_t cmd, input logic [7:0] opnd,
                                            input logic [15:0] pair, input logic [7:0] disp,
                                            input logic [2:0] bsel, input logic [15:0] hl,
                                            input logic [15:0] sp, input logic [7:0] a_prev,
                                            input flags_t f_prev);
    out_word_t   r;
    int unsigned ua, uv, t, cin;
    logic [7:0]  a8, src, rot, r8;
    logic [15:0] r16, spo, sum16;
    logic        z, n, h, c, acc_form;
    a8  = a_prev;
    ua  = a_prev;
    uv  = opnd;
    z   = f_prev.z;
    n   = f_prev.n;
    h   = f_prev.h;
    c   = f_prev.c;
    r8  = '0;
    r16 = '0;
    spo = sp;
    case (cmd)
      CMD_ADD, CMD_ADC: begin
        cin = (cmd == CMD_ADC && c) ? 1 : 0;
        t   = ua + uv + cin;
        h   = ((ua & 15) + (uv & 15) + cin) > 15;
        c   = t > 255;
        a8  = t[7:0];
        z   = a8 == 8'h00;
        n   = 1'b0;
      end
      CMD_SUB, CMD_SBC, CMD_CP: begin
        cin = (cmd == CMD_SBC && c) ? 1 : 0;
        t   = (ua - uv - cin) & 32'h1FF;
        h   = ((ua ^ uv ^ t) & 32'h10) != 0;
        c   = ua < uv + cin;
        n   = 1'b1;
        z   = t[7:0] == 8'h00;
        // compare leaves A alone
        if (cmd != CMD_CP) a8 = t[7:0];
      end
      CMD_AND: begin
        a8 = a8 & opnd;
        z  = a8 == 8'h00;
        {n, h, c} = 3'b010;
      end
      CMD_OR: begin
        a8 = a8 | opnd;
        z  = a8 == 8'h00;
        {n, h, c} = 3'b000;
      end
      CMD_XOR: begin
        a8 = a8 ^ opnd;
        z  = a8 == 8'h00;
        {n, h, c} = 3'b000;
      end
      CMD_INC8: begin
        h  = opnd[3:0] == 4'hF;
        r8 = opnd + 8'd1;
        z  = r8 == 8'h00;
        n  = 1'b0;
      end
      CMD_DEC8: begin
        h  = opnd[3:0] == 4'h0;
        r8 = opnd - 8'd1;
        z  = r8 == 8'h00;
        n  = 1'b1;
      end
      CMD_INC16: r16 = pair + 16'd1;
      CMD_DEC16: r16 = pair - 16'd1;
      CMD_DAA: begin
        // correct by 6 and/or 0x60; carry can only be set here
        t = ua;
        if (n) begin
          if (h) t = (t - 6) & 32'hFF;
          if (c) t = t - 32'h60;
        end else begin
          if (h || (t & 15) > 9) t = t + 6;
          if (c || t > 32'h9F) t = t + 32'h60;
        end
        if ((t & 32'h100) != 0) c = 1'b1;
        a8 = t[7:0];
        z  = a8 == 8'h00;
        h  = 1'b0;
      end
      CMD_RLC, CMD_RLCA, CMD_RL, CMD_RLA, CMD_RRC, CMD_RRCA, CMD_RR, CMD_RRA: begin
        acc_form = (cmd == CMD_RLCA) || (cmd == CMD_RLA) ||
                   (cmd == CMD_RRCA) || (cmd == CMD_RRA);
        src = acc_form ? a8 : opnd;
        case (cmd)
          CMD_RLC, CMD_RLCA: rot = {src[6:0], src[7]};
          CMD_RL,  CMD_RLA:  rot = {src[6:0], c};
          CMD_RRC, CMD_RRCA: rot = {src[0], src[7:1]};
          default:           rot = {c, src[7:1]};
        endcase
        c = (cmd <= CMD_RLA) ? src[7] : src[0];
        n = 1'b0;
        h = 1'b0;
        // accumulator rotates always clear Z
        if (acc_form) begin
          a8 = rot;
          z  = 1'b0;
        end else begin
          r8 = rot;
          z  = rot == 8'h00;
        end
      end
      CMD_SLA, CMD_SRA, CMD_SRL, CMD_SWAP: begin
        case (cmd)
          CMD_SLA: begin
            c  = opnd[7];
            r8 = {opnd[6:0], 1'b0};
          end
          CMD_SRA: begin
            c  = opnd[0];
            r8 = {opnd[7], opnd[7:1]};
          end
          CMD_SRL: begin
            c  = opnd[0];
            r8 = {1'b0, opnd[7:1]};
          end
          default: begin
            c  = 1'b0;
            r8 = {opnd[3:0], opnd[7:4]};
          end
        endcase
        z = r8 == 8'h00;
        n = 1'b0;
        h = 1'b0;
      end
      CMD_BIT: begin
        z = !opnd[bsel];
        n = 1'b0;
        h = 1'b1;
      end
      CMD_RES: begin
        r8       = opnd;
        r8[bsel] = 1'b0;
      end
      CMD_SET: begin
        r8       = opnd;
        r8[bsel] = 1'b1;
      end
      CMD_ADD_HL: begin
        t   = hl + pair;
        h   = ((hl & 32'hFFF) + (pair & 32'hFFF)) > 32'hFFF;
        c   = t > 32'hFFFF;
        n   = 1'b0;
        r16 = t[15:0];
      end
      CMD_ADD_SP, CMD_LD_HLSP: begin
        // flags come from the unsigned low byte, the sum from the signed offset
        c     = ((sp & 32'hFF) + disp) > 32'hFF;
        h     = ((sp & 32'hF) + (disp & 32'hF)) > 32'hF;
        z     = 1'b0;
        n     = 1'b0;
        sum16 = sp + {{8{disp[7]}}, disp};
        if (cmd == CMD_ADD_SP) spo = sum16;
        else r16 = sum16;
      end
      default: begin
        // load AF: drop the low flag nibble
        a8 = pair[15:8];
        {z, n, h, c} = pair[7:4];
      end
    endcase
    r.result8  = r8;
    r.result16 = r16;
    r.sp_out   = spo;
    r.acc      = a8;
    r.flags.z  = z;
    r.flags.n  = n;
    r.flags.h  = h;
    r.flags.c  = c;
    return r;
  endfunction

  // Compare leaving words, then predict the entering word
  always @(posedge clk) begin
    out_word_t want, got;
    if (rst) begin
      acc_model  = '0;
      flag_model = '0;
      alu_result_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.result8  = out_data[7:0];
        got.result16 = out_data[23:8];
        got.sp_out   = out_data[39:24];
        got.acc      = out_data[47:40];
        got.flags.z  = out_data[48];
        got.flags.n  = out_data[49];
        got.flags.h  = out_data[50];
        got.flags.c  = out_data[51];
        if (alu_result_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("[%0t] unexpected result word %h", $realtime, out_data);
        end else begin
          want = alu_result_q.pop_front();
          if (got.result8 !== want.result8 || got.result16 !== want.result16 ||
              got.sp_out !== want.sp_out || got.acc !== want.acc ||
              got.flags !== want.flags) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("[%0t] mismatch exp r8=%h r16=%h sp=%h a=%h znhc=%b",
                       $realtime, want.result8, want.result16, want.sp_out, want.acc,
                       want.flags, " got r8=%h r16=%h sp=%h a=%h znhc=%b",
                       got.result8, got.result16, got.sp_out, got.acc, got.flags);
          end
        end
      end
      if (in_valid && in_ready) begin
        want = alu_predict(cmd_t'(in_user[4:0]), in_data[7:0], in_data[23:8],
                           in_data[31:24], in_data[34:32], in_data[50:35],
                           in_data[66:51], acc_model, flag_model);
        acc_model  = want.acc;
        flag_model = want.flags;
        alu_result_q.push_back(want);
      end
    end
    outstanding <= alu_result_q.size();
    mismatches  <= fail_cnt;
  end

endmodule

### test/tb_lr35902_alu_flags.sv
// ----------------------------------------------------------------------------
// tb_lr35902_alu_flags: stimulus and verdict for the accumulator/flags ALU
// Runs a directed pass over every command and the decimal adjust, rotate and
// stack offset corners, then random commands with random gaps on both sides
// and one long output stall. The checker beside the block does the compare.
// ----------------------------------------------------------------------------
module tb_lr35902_alu_flags;
  import lralu_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_CMDS = 760;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int                     mismatches;
  int                     outstanding;
  int                     tx_count = 0;
  int                     rx_count = 0;
  int                     idle_cycles = 0;

  lr35902_alu_flags u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lr35902_alu_flags_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_user     (s_axis_tuser),
    .in_data     (s_axis_tdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Gap before a word; every fourth stretch of 50 words runs back to back
  function automatic int draw_wait(input int count);
    if ((count / 50) % 4 == 3) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Favor byte corners that hit nibble and sign boundaries
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h0F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_pair();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0FFF;
      3: return 16'h00FF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input cmd_t cmd, input logic [7:0] opnd, input logic [15:0] pair,
                           input logic [7:0] disp, input logic [2:0] bsel,
                           input logic [15:0] hl, input logic [15:0] sp);
    int gap;
    gap = draw_wait(tx_count);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {5'b0, sp, hl, bsel, disp, pair, opnd};
    do @(posedge clk); while (!s_axis_tready);
    tx_count++;
  endtask

  // Accept result words; stall once long enough to back up the input
  initial begin
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      hold = (rx_count == 300) ? 200 : draw_wait(rx_count);
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      rx_count++;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL lr35902_alu_flags");
      $finish;
    end
  end

  initial begin
    cmd_t cmd;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every command once, alternating all-zero and all-one operands (offset 0x7F or 0x80)
    for (int k = 0; k < 32; k++) begin
      if (k[0])
        send_word(cmd_t'(k), 8'hFF, 16'hFFFF, 8'h80, 3'(k), 16'hFFFF, 16'hFFFF);
      else
        send_word(cmd_t'(k), 8'h00, 16'h0000, 8'h7F, 3'(k), 16'h0000, 16'h0000);
    end

    // Decimal adjust: add path with the 0x60 step into carry, subtract paths
    send_word(CMD_LOAD_AF, 8'h00, 16'h9A0F, 8'h00, 3'd0, 16'h0000, 16'h0000);
    send_word(CMD_DAA,     8'h00, 16'h0000, 8'h00, 3'd0, 16'h0000, 16'h0000);
    send_word(CMD_LOAD_AF, 8'h00, 16'h00F0, 8'h00, 3'd0, 16'h0000, 16'h0000);
    send_word(CMD_DAA,     8'h00, 16'h0000, 8'h00, 3'd0, 16'h0000, 16'h0000);
    send_word(CMD_LOAD_AF, 8'h00, 16'h0050, 8'h00, 3'd0, 16'h0000, 16'h0000);
    send_word(CMD_DAA,     8'h00, 16'h0000, 8'h00, 3'd0, 16'h0000, 16'h0000);
    // Accumulator rotate of zero still clears Z
    send_word(CMD_LOAD_AF, 8'h00, 16'h0080, 8'h00, 3'd0, 16'h0000, 16'h0000);
    send_word(CMD_RLA,     8'h00, 16'h0000, 8'h00, 3'd0, 16'h0000, 16'h0000);
    // Stack offsets at both ends of the signed range
    send_word(CMD_ADD_SP,  8'h00, 16'h0000, 8'h80, 3'd0, 16'h0000, 16'h0000);
    send_word(CMD_LD_HLSP, 8'h00, 16'h0000, 8'h7F, 3'd0, 16'h1234, 16'hFFFF);

    // Random commands, often after a random A and flag load
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      cmd = cmd_t'($urandom_range(0, 31));
      if ($urandom_range(0, 3) == 0)
        send_word(CMD_LOAD_AF, pick_byte(), 16'($urandom), pick_byte(), 3'($urandom),
                  pick_pair(), pick_pair());
      send_word(cmd, pick_byte(), pick_pair(), pick_byte(), 3'($urandom),
                pick_pair(), pick_pair());
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then give the pipeline time to show any extra word
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS lr35902_alu_flags");
    else
      $display("FAIL lr35902_alu_flags");
    $finish;
  end

endmodule
